FILE: src/ps2s1_pkg.sv
`default_nettype none

package ps2s1_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 7;
    localparam int SKIP_W  = 3;

    localparam logic [BYTE_W-1:0] PREFIX_EXT   = 8'hE0;
    localparam logic [BYTE_W-1:0] PREFIX_PAUSE = 8'hE1;
    localparam logic [BYTE_W-1:0] USAGE_PAUSE  = 8'h48;
    localparam logic [BYTE_W-1:0] USAGE_NONE   = 8'h00;
    localparam logic [SKIP_W-1:0] PAUSE_TAIL   = 3'd5;

    localparam logic [BYTE_W-1:0] MAIN_MAP [0:127] = '{
        8'd0,   8'd41,  8'd30,  8'd31,  8'd32,  8'd33,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd45,  8'd46,  8'd42,  8'd43,
        8'd20,  8'd26,  8'd8,   8'd21,  8'd23,  8'd28,  8'd24,  8'd12,
        8'd18,  8'd19,  8'd47,  8'd48,  8'd40,  8'd224, 8'd4,   8'd22,
        8'd7,   8'd9,   8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd51,
        8'd52,  8'd53,  8'd225, 8'd49,  8'd29,  8'd27,  8'd6,   8'd25,
        8'd5,   8'd17,  8'd16,  8'd54,  8'd55,  8'd56,  8'd229, 8'd85,
        8'd226, 8'd44,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd83,  8'd71,  8'd95,
        8'd96,  8'd97,  8'd86,  8'd92,  8'd93,  8'd94,  8'd87,  8'd89,
        8'd90,  8'd91,  8'd98,  8'd99,  8'd0,   8'd0,   8'd0,   8'd68,
        8'd69,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

    localparam logic [BYTE_W-1:0] EXT_MAP [0:127] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd88,  8'd228, 8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd84,  8'd0,   8'd70,
        8'd230, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd72,  8'd74,
        8'd82,  8'd75,  8'd0,   8'd80,  8'd0,   8'd79,  8'd0,   8'd77,
        8'd81,  8'd78,  8'd73,  8'd76,  8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd227, 8'd231, 8'd101, 8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

endpackage

`default_nettype wire

FILE: src/ps2_set1_scancode_decoder.sv
`default_nettype none

// channel   signals                           width        direction
// input     in_valid in_ready scan_byte       8            keyboard -> block
// output    out_valid out_ready key_usage     8 + 1 + 1    block -> consumer
//           key_down last_of_run
//
// one item per cycle while the output register is free; an E1 prefix holds the input register
// while its press and release events leave through the output register
// rst_n clears the prefix and skip state and both valid flags
// a stalled output register stalls the input register only when the
// byte there needs an event; swallowed bytes drain regardless

module ps2_set1_scancode_decoder
    import ps2s1_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] scan_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      key_usage,
    output logic                   key_down,
    output logic                   last_of_run
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              ext_reg, ext_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] usage_reg, usage_next;
    logic              down_reg, down_next;
    logic              last_reg, last_next;

    logic              skipping, is_pause, is_ext, has_key, needs_out;
    logic              out_free, load_out, s1_done;
    logic [BYTE_W-1:0] lookup;

    // decode of the held byte
    always_comb
    begin
        skipping  = (skip_reg != '0);
        is_pause  = !skipping && (in_byte_reg == PREFIX_PAUSE);
        is_ext    = !skipping && (in_byte_reg == PREFIX_EXT);
        lookup    = ext_reg ? EXT_MAP[in_byte_reg[IDX_W-1:0]]
                            : MAIN_MAP[in_byte_reg[IDX_W-1:0]];
        has_key   = !skipping && !is_pause && !is_ext && (lookup != USAGE_NONE);
        needs_out = is_pause || has_key;
        out_free  = !out_valid_reg || out_ready;
        load_out  = in_valid_reg && needs_out && out_free;
        s1_done   = in_valid_reg
                    && (!needs_out || (out_free && (!is_pause || phase_reg)));
        in_ready  = !in_valid_reg || s1_done;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end

        ext_next  = ext_reg;
        skip_next = skip_reg;
        if (s1_done)
        begin
            if (skipping)
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end
            else if (is_pause)
            begin
                skip_next = PAUSE_TAIL;
            end
            else if (is_ext)
            begin
                ext_next = 1'b1;
            end
            else
            begin
                ext_next = 1'b0;
            end
        end

        phase_next = phase_reg;
        if (s1_done)
        begin
            phase_next = 1'b0;
        end
        else if (load_out && is_pause)
        begin
            phase_next = 1'b1;
        end

        out_valid_next = out_valid_reg && !out_ready;
        usage_next     = usage_reg;
        down_next      = down_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (is_pause)
            begin
                usage_next = USAGE_PAUSE;
                down_next  = !phase_reg;
                last_next  = phase_reg;
            end
            else
            begin
                usage_next = lookup;
                down_next  = !in_byte_reg[BYTE_W-1];
                last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ext_reg       <= 1'b0;
            skip_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            ext_reg       <= ext_next;
            skip_reg      <= skip_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= scan_byte;
        end
        usage_reg <= usage_next;
        down_reg  <= down_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_usage   = usage_reg;
    assign key_down    = down_reg;
    assign last_of_run = last_reg;

    a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (in_valid_reg && !skipping && (in_byte_reg == PREFIX_PAUSE)))
        else $error("second pause event pending without a pause byte held");

    a_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (out_valid_reg && !last_reg && down_reg))
        else $error("pause press not in the output register");

    a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= PAUSE_TAIL)
        else $error("skip count out of range");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (usage_reg == USAGE_PAUSE && down_reg))
        else $error("only the pause press may be a non-final event");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;

    import ps2s1_pkg::BYTE_W;

    localparam logic [7:0] EXT_CODE   = 8'hE0;
    localparam logic [7:0] PAUSE_CODE = 8'hE1;
    localparam logic [7:0] PAUSE_KEY  = 8'h48;
    localparam logic [7:0] NO_KEY     = 8'h00;
    localparam logic [2:0] SKIP_LEN   = 3'd5;
    localparam int         IDLE_PCT   = 37;
    localparam int         N_BYTES    = 1150;

    // set 1 main table, indices 00..58; everything above is empty
    localparam logic [7:0] MAIN_USAGE [0:88] = '{
        8'd0,   8'd41,  8'd30,  8'd31,  8'd32,  8'd33,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd45,  8'd46,  8'd42,  8'd43,
        8'd20,  8'd26,  8'd8,   8'd21,  8'd23,  8'd28,  8'd24,  8'd12,
        8'd18,  8'd19,  8'd47,  8'd48,  8'd40,  8'd224, 8'd4,   8'd22,
        8'd7,   8'd9,   8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd51,
        8'd52,  8'd53,  8'd225, 8'd49,  8'd29,  8'd27,  8'd6,   8'd25,
        8'd5,   8'd17,  8'd16,  8'd54,  8'd55,  8'd56,  8'd229, 8'd85,
        8'd226, 8'd44,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd83,  8'd71,  8'd95,
        8'd96,  8'd97,  8'd86,  8'd92,  8'd93,  8'd94,  8'd87,  8'd89,
        8'd90,  8'd91,  8'd98,  8'd99,  8'd0,   8'd0,   8'd0,   8'd68,
        8'd69
    };

    localparam logic [6:0] EXT_KEYS [0:18] = '{
        7'h1C, 7'h1D, 7'h35, 7'h37, 7'h38, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4B,
        7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C, 7'h5D
    };

    typedef struct packed {
        logic [7:0] usage;
        logic       down;
        logic       last;
    } key_event_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] scan_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] key_usage;
    logic              key_down;
    logic              last_of_run;

    logic [7:0]  byte_queue [$];
    key_event_t  key_events [$];
    key_event_t  want;
    logic        ext_seen;
    logic [2:0]  skip_left;
    int          fail_count;
    int          cycle_count;
    logic        hold_off;
    logic        calm;

    ps2_set1_scancode_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_usage   (key_usage),
        .key_down    (key_down),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] main_lookup(input logic [6:0] idx);
        if (idx <= 7'd88)
            return MAIN_USAGE[idx];
        return NO_KEY;
    endfunction

    function automatic logic [7:0] ext_lookup(input logic [6:0] idx);
        for (int i = 0; i < 19; i++)
            if (EXT_KEYS[5'(i)] == idx)
                case (idx)
                    7'h1C: return 8'd88;
                    7'h1D: return 8'd228;
                    7'h35: return 8'd84;
                    7'h37: return 8'd70;
                    7'h38: return 8'd230;
                    7'h46: return 8'd72;
                    7'h47: return 8'd74;
                    7'h48: return 8'd82;
                    7'h49: return 8'd75;
                    7'h4B: return 8'd80;
                    7'h4D: return 8'd79;
                    7'h4F: return 8'd77;
                    7'h50: return 8'd81;
                    7'h51: return 8'd78;
                    7'h52: return 8'd73;
                    7'h53: return 8'd76;
                    7'h5B: return 8'd227;
                    7'h5C: return 8'd231;
                    default: return 8'd101;
                endcase
        return NO_KEY;
    endfunction

    task automatic decode_scan(input logic [7:0] b);
        logic [7:0] usage;
        if (skip_left != 3'd0)
            skip_left = skip_left - 3'd1;
        else if (b == PAUSE_CODE)
        begin
            skip_left = SKIP_LEN;
            key_events.push_back('{usage: PAUSE_KEY, down: 1'b1, last: 1'b0});
            key_events.push_back('{usage: PAUSE_KEY, down: 1'b0, last: 1'b1});
        end
        else if (b == EXT_CODE)
            ext_seen = 1'b1;
        else
        begin
            usage = ext_seen ? ext_lookup(b[6:0]) : main_lookup(b[6:0]);
            ext_seen = 1'b0;
            if (usage != NO_KEY)
                key_events.push_back('{usage: usage, down: !b[7], last: 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
    end

    // consumer stops during hold_off early on, then a stretch with no idling (calm)
    assign hold_off = cycle_count >= 400 && cycle_count < 700;
    assign calm     = cycle_count >= 1500 && cycle_count < 2300;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            scan_byte <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_scan(scan_byte);
            if (!in_valid || in_ready)
            begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid  <= 1'b1;
                    scan_byte <= byte_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (key_events.size() == 0)
                begin
                    $error("unexpected item: key_usage %0d key_down %0d last_of_run %0d",
                           key_usage, key_down, last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = key_events.pop_front();
                    if (key_usage !== want.usage)
                    begin
                        $error("key_usage: expected %0d, got %0d", want.usage, key_usage);
                        fail_count++;
                    end
                    if (key_down !== want.down)
                    begin
                        $error("key_down: expected %0d, got %0d", want.down, key_down);
                        fail_count++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                        fail_count++;
                    end
                end
            end
            out_ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_key(input logic is_ext);
        logic [6:0] idx;
        if (is_ext)
        begin
            byte_queue.push_back(EXT_CODE);
            idx = EXT_KEYS[5'($urandom_range(18))];
        end
        else
        begin
            idx = 7'($urandom_range(1, 88));
            while (main_lookup(idx) == NO_KEY)
                idx = 7'($urandom_range(1, 88));
        end
        byte_queue.push_back({1'($urandom_range(1)), idx});
    endtask

    initial
    begin
        int pick;
        ext_seen   = 1'b0;
        skip_left  = 3'd0;
        fail_count = 0;

        // directed: table ends, make and break, extended keys, fake shift,
        // double prefix, ctrl+break, a full pause sequence, unknown codes
        byte_queue = '{8'h00, 8'hFF, 8'h01, 8'h81, 8'hE0, 8'h1C, 8'hE0, 8'h9C,
                       8'hE0, 8'h2A, 8'hE0, 8'hE0, 8'h46, 8'hE1, 8'h1D, 8'h45,
                       8'hE1, 8'h9D, 8'hC5, 8'h58, 8'hD8, 8'hE0, 8'hFF, 8'h54};

        while (byte_queue.size() < N_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                add_key(1'b0);
            else if (pick < 65)
                add_key(1'b1);
            else if (pick < 70)
                byte_queue = {byte_queue, PAUSE_CODE, 8'h1D, 8'h45, PAUSE_CODE, 8'h9D, 8'hC5};
            else if (pick < 75)
            begin
                byte_queue.push_back(EXT_CODE);
                byte_queue.push_back($urandom_range(1) ? 8'h2A : 8'hB6);
            end
            else if (pick < 90)
                byte_queue.push_back(8'($urandom_range(255)));
            else
            begin
                byte_queue.push_back(EXT_CODE);
                byte_queue.push_back(8'($urandom_range(255)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (key_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/ps2s1_pkg.sv
src/ps2_set1_scancode_decoder.sv
verif/tb_top.sv
